// ===== rtl/uer_pkg.sv =====
// Shared types and constants of the ultrasonic echo ranger.
package uer_pkg;

  localparam int unsigned PULSE_W    = 24;
  localparam int unsigned TIMEOUT_W  = 24;
  localparam int unsigned TRIG_W     = 8;
  localparam int unsigned CM_W       = 19;
  localparam int unsigned INCH_W     = 17;
  localparam int unsigned FRAC_BITS  = 24;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CFG_IDX_W  = 2;

  // Q0.24 scale factors: 0.017 cm and 0.00665 inch per microsecond.
  localparam int unsigned CM_MUL_W   = 19;
  localparam int unsigned INCH_MUL_W = 17;
  localparam logic [CM_MUL_W-1:0]   CM_MUL   = 19'd285213;
  localparam logic [INCH_MUL_W-1:0] INCH_MUL = 17'd111569;
  localparam int unsigned CM_PROD_W   = PULSE_W + CM_MUL_W;
  localparam int unsigned INCH_PROD_W = PULSE_W + INCH_MUL_W;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST    = 24'd1000000;
  localparam logic                 ECHO_LVL_RST   = 1'b1;
  localparam logic [TRIG_W-1:0]    TRIG_LOW_RST   = 8'd2;
  localparam logic [TRIG_W-1:0]    TRIG_HIGH_RST  = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT   = 2'd0,
    CFG_ECHO_LVL  = 2'd1,
    CFG_TRIG_LOW  = 2'd2,
    CFG_TRIG_HIGH = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE          = 3'd0,
    PH_TRIG_LOW      = 3'd1,
    PH_TRIG_HIGH     = 3'd2,
    PH_WAIT_INACTIVE = 3'd3,
    PH_WAIT_ACTIVE   = 3'd4,
    PH_MEASURE       = 3'd5
  } phase_e;

  typedef enum logic {
    KIND_TICK  = 1'b0,
    KIND_START = 1'b1
  } kind_e;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] timeout_us;
    logic                 echo_active_level;
    logic [TRIG_W-1:0]    trigger_low_ticks;
    logic [TRIG_W-1:0]    trigger_high_ticks;
  } cfg_t;

  typedef struct packed {
    logic kind;
    logic echo_level;
  } in_word_t;

  typedef struct packed {
    logic               trigger_level;
    logic               busy_res;
    logic               done_res;
    logic               timed_out;
    logic [PULSE_W-1:0] pulse_us;
  } status_t;

  typedef struct packed {
    logic               trigger_level;
    logic               busy_res;
    logic               done_res;
    logic               timed_out;
    logic [PULSE_W-1:0] pulse_us;
    logic [CM_W-1:0]    distance_cm;
    logic [INCH_W-1:0]  distance_inch;
  } out_word_t;

endpackage

// ===== rtl/uer_cfg_regs.sv =====
// Configuration register file of the echo ranger.
module uer_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output uer_pkg::cfg_t                  cfg_o
);

  uer_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (uer_pkg::cfg_idx_e'(cfg_idx_i))
        uer_pkg::CFG_TIMEOUT:   cfg_d.timeout_us = cfg_wdata_i[uer_pkg::TIMEOUT_W-1:0];
        uer_pkg::CFG_ECHO_LVL:  cfg_d.echo_active_level = cfg_wdata_i[0];
        uer_pkg::CFG_TRIG_LOW:  cfg_d.trigger_low_ticks = cfg_wdata_i[uer_pkg::TRIG_W-1:0];
        uer_pkg::CFG_TRIG_HIGH: cfg_d.trigger_high_ticks = cfg_wdata_i[uer_pkg::TRIG_W-1:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_us         <= uer_pkg::TIMEOUT_RST;
      cfg_q.echo_active_level  <= uer_pkg::ECHO_LVL_RST;
      cfg_q.trigger_low_ticks  <= uer_pkg::TRIG_LOW_RST;
      cfg_q.trigger_high_ticks <= uer_pkg::TRIG_HIGH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/uer_ctrl.sv =====
// Measurement sequencer: phase machine, counters and the status stage register.
module uer_ctrl #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  uer_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  input  uer_pkg::in_word_t in_word_i,
  output logic              in_ready_o,
  input  logic              s2_ready_i,
  output logic              s1_valid_o,
  output uer_pkg::status_t  s1_o
);

  uer_pkg::phase_e phase_q, phase_d;
  logic [uer_pkg::TRIG_W-1:0]  trig_cnt_q, trig_cnt_d, trig_inc;
  logic [COUNT_WIDTH-1:0]      elapsed_q, elapsed_d, elapsed_inc;
  logic [COUNT_WIDTH-1:0]      width_q, width_d, width_inc;
  logic [uer_pkg::PULSE_W-1:0] last_pulse_q, last_pulse_d;
  logic                        last_to_q, last_to_d;
  logic                        done;
  logic                        active;
  logic                        timeout_hit;
  logic [31:0]                 width_ext;
  logic                        accept;
  logic                        s1_valid_q;
  uer_pkg::status_t            s1_q;

  assign in_ready_o = !s1_valid_q || s2_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign active      = (in_word_i.echo_level == cfg_i.echo_active_level);
  assign trig_inc    = trig_cnt_q + 1'b1;
  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
  assign width_inc   = (width_q == '1) ? width_q : width_q + 1'b1;
  assign timeout_hit = 32'(elapsed_inc) >= 32'(cfg_i.timeout_us);
  assign width_ext   = 32'(width_inc);

  always_comb begin
    phase_d      = phase_q;
    trig_cnt_d   = trig_cnt_q;
    elapsed_d    = elapsed_q;
    width_d      = width_q;
    last_pulse_d = last_pulse_q;
    last_to_d    = last_to_q;
    done         = 1'b0;
    if (in_word_i.kind == uer_pkg::KIND_START) begin
      // A start request while a measurement runs is dropped.
      if (phase_q == uer_pkg::PH_IDLE) begin
        trig_cnt_d = '0;
        phase_d    = (cfg_i.trigger_low_ticks == '0) ? uer_pkg::PH_TRIG_HIGH
                                                     : uer_pkg::PH_TRIG_LOW;
      end
    end else begin
      unique case (phase_q)
        uer_pkg::PH_IDLE: begin
          phase_d = uer_pkg::PH_IDLE;
        end
        uer_pkg::PH_TRIG_LOW: begin
          trig_cnt_d = trig_inc;
          if (trig_inc >= cfg_i.trigger_low_ticks) begin
            trig_cnt_d = '0;
            phase_d    = uer_pkg::PH_TRIG_HIGH;
          end
        end
        uer_pkg::PH_TRIG_HIGH: begin
          trig_cnt_d = trig_inc;
          if (trig_inc >= cfg_i.trigger_high_ticks) begin
            trig_cnt_d = '0;
            elapsed_d  = '0;
            width_d    = '0;
            phase_d    = uer_pkg::PH_WAIT_INACTIVE;
          end
        end
        uer_pkg::PH_WAIT_INACTIVE, uer_pkg::PH_WAIT_ACTIVE, uer_pkg::PH_MEASURE: begin
          elapsed_d = elapsed_inc;
          if (phase_q == uer_pkg::PH_MEASURE) begin
            width_d = width_inc;
          end
          // The timeout takes precedence over an echo edge on the same tick.
          if (timeout_hit) begin
            last_pulse_d = '0;
            last_to_d    = 1'b1;
            phase_d      = uer_pkg::PH_IDLE;
            done         = 1'b1;
          end else if (phase_q == uer_pkg::PH_WAIT_INACTIVE) begin
            if (!active) begin
              phase_d = uer_pkg::PH_WAIT_ACTIVE;
            end
          end else if (phase_q == uer_pkg::PH_WAIT_ACTIVE) begin
            if (active) begin
              width_d = '0;
              phase_d = uer_pkg::PH_MEASURE;
            end
          end else if (!active) begin
            last_pulse_d = width_ext[uer_pkg::PULSE_W-1:0];
            last_to_d    = 1'b0;
            phase_d      = uer_pkg::PH_IDLE;
            done         = 1'b1;
          end
        end
        default: begin
          phase_d = uer_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= uer_pkg::PH_IDLE;
      trig_cnt_q   <= '0;
      elapsed_q    <= '0;
      width_q      <= '0;
      last_pulse_q <= '0;
      last_to_q    <= 1'b0;
      s1_valid_q   <= 1'b0;
    end else begin
      if (accept) begin
        phase_q      <= phase_d;
        trig_cnt_q   <= trig_cnt_d;
        elapsed_q    <= elapsed_d;
        width_q      <= width_d;
        last_pulse_q <= last_pulse_d;
        last_to_q    <= last_to_d;
        s1_valid_q   <= 1'b1;
      end else if (s2_ready_i) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.trigger_level <= (phase_d == uer_pkg::PH_TRIG_HIGH);
      s1_q.busy_res      <= (phase_d != uer_pkg::PH_IDLE);
      s1_q.done_res      <= done;
      s1_q.timed_out     <= last_to_d;
      s1_q.pulse_us      <= last_pulse_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;

endmodule

// ===== rtl/uer_conv.sv =====
// Width-to-distance conversion and the output register.
module uer_conv (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s1_valid_i,
  input  uer_pkg::status_t   s1_i,
  output logic               s2_ready_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output uer_pkg::out_word_t out_word_o
);

  logic [uer_pkg::CM_PROD_W-1:0]   cm_prod;
  logic [uer_pkg::INCH_PROD_W-1:0] inch_prod;
  logic                            out_valid_q;
  uer_pkg::out_word_t              out_q;

  assign cm_prod   = uer_pkg::CM_PROD_W'(s1_i.pulse_us) *
                     uer_pkg::CM_PROD_W'(uer_pkg::CM_MUL);
  assign inch_prod = uer_pkg::INCH_PROD_W'(s1_i.pulse_us) *
                     uer_pkg::INCH_PROD_W'(uer_pkg::INCH_MUL);

  assign s2_ready_o = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready_o) begin
      out_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready_o && s1_valid_i) begin
      out_q.trigger_level <= s1_i.trigger_level;
      out_q.busy_res      <= s1_i.busy_res;
      out_q.done_res      <= s1_i.done_res;
      out_q.timed_out     <= s1_i.timed_out;
      out_q.pulse_us      <= s1_i.pulse_us;
      out_q.distance_cm   <= cm_prod[uer_pkg::CM_PROD_W-1:uer_pkg::FRAC_BITS];
      out_q.distance_inch <= inch_prod[uer_pkg::INCH_PROD_W-1:uer_pkg::FRAC_BITS];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== rtl/ultrasonic_echo_ranger_unit.sv =====
// A word's result passes the sequencer's status register, then the converter's output register.
// One word per cycle unless stalled; the sequencer's phase update is a single registered step.
// The input stalls only while both pipeline registers hold results the consumer has not taken.
// Reset (rst_ni low, asynchronous) empties the pipeline, returns the sequencer to idle with
// zero counters and zero last results, and loads the register reset values.
// Top level of the ultrasonic echo ranger.
module ultrasonic_echo_ranger_unit #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  uer_pkg::in_word_t              in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output uer_pkg::out_word_t             out_word_o
);

  // Holds the four settings; the user must change them only while no word is in flight (not enforced).
  uer_pkg::cfg_t    cfg;
  logic             in_ready;
  logic             s2_ready;
  logic             s1_valid;
  uer_pkg::status_t s1;

  uer_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Stage one: each accepted word advances the phase machine by one tick (or starts a
  // measurement) and the resulting status, including the last pulse width, is registered.
  uer_ctrl #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .in_ready_o (in_ready),
    .s2_ready_i (s2_ready),
    .s1_valid_o (s1_valid),
    .s1_o       (s1)
  );

  // Stage two: the pulse width is scaled to centimeters and inches by Q0.24 constant
  // multiplies and the full result word is held in the output register.
  uer_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .s1_i        (s1),
    .s2_ready_o  (s2_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  assign in_stall_o = !in_ready;

endmodule

// ===== rtl/uer_checker.sv =====
// Port-level checks of the echo ranger and their binding to the top level.
module uer_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input uer_pkg::out_word_t out_word_o
);

  // A result word that is not taken stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed");

  // The word that finishes a measurement leaves the block idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.done_res |-> !out_word_o.busy_res)
    else $error("finished measurement still reported busy");

  // The trigger pulse is only driven during a measurement.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.trigger_level |-> out_word_o.busy_res)
    else $error("trigger high while idle");

  // A timed-out measurement reports a zero width.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.timed_out |-> out_word_o.pulse_us == '0)
    else $error("timeout with nonzero pulse width");

  // Zero width converts to zero distance in both units.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.pulse_us == '0 |->
      out_word_o.distance_cm == '0 && out_word_o.distance_inch == '0)
    else $error("nonzero distance for zero width");

endmodule

bind ultrasonic_echo_ranger_unit uer_checker u_uer_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
